### rtl/lcrb_pkg.sv
// Lapped chunk ring buffer: shared package.
// Command, status, register and job codes, the queue job word and the
// configuration bundle. No dependencies.
package lcrb_pkg;

	localparam int DEF_MAX_SLOTS       = 64;
	localparam int DEF_MAX_CHUNK_BYTES = 64;
	localparam int DEF_LAP_BITS        = 32;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] REG_RESET_VALUE = 7'd64;

	// input commands
	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_READ  = 3'd1;
	localparam logic [2:0] CMD_AVAIL = 3'd2;
	localparam logic [2:0] CMD_POS   = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;

	// register indexes
	localparam logic REG_CHUNK_SIZE = 1'b0;
	localparam logic REG_NODES      = 1'b1;

	// job kinds handed from front to back
	localparam logic [1:0] JOB_EMIT  = 2'd0;
	localparam logic [1:0] JOB_READ  = 2'd1;
	localparam logic [1:0] JOB_AVAIL = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] amount;
		logic [5:0]  res_slot;
		logic [31:0] res_lap;
		logic [5:0]  cs;
		logic [6:0]  wslot;
	} job_t;

	typedef struct packed {
		logic [6:0] chunk_size;
		logic [6:0] nodes;
		logic [6:0] fill;      // slots [0, fill) hold a written length
	} cfg_t;

	function automatic logic [6:0] clamp_reg(input logic [6:0] v, input int hi);
		logic [6:0] r;
		r = v;
		if (v == 7'd0)
			r = 7'd1;
		else if (int'(v) > hi)
			r = 7'(hi);
		return r;
	endfunction

endpackage

### rtl/lcrb_ram.sv
// Lapped chunk ring buffer: generic single-write, single-read RAM.
// Registered read data, held while no read is issued. No dependencies.
module lcrb_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

### rtl/lcrb_queue.sv
// Lapped chunk ring buffer: short job queue between front and back.
// Depends on lcrb_pkg (job_t, QUEUE_DEPTH).
module lcrb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lcrb_pkg::job_t push_job,
	input  logic          pop,
	output lcrb_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	localparam int DEPTH = lcrb_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lcrb_pkg::job_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PTR_W+1)'(DEPTH));
	assign head  = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/lcrb_front.sv
// Lapped chunk ring buffer: front end. Takes input words and config writes,
// keeps the writer position, stores written bytes and lengths, builds jobs.
// Depends on lcrb_pkg.
module lcrb_front #(
	parameter int MAX_SLOTS       = lcrb_pkg::DEF_MAX_SLOTS,
	parameter int MAX_CHUNK_BYTES = lcrb_pkg::DEF_MAX_CHUNK_BYTES,
	parameter int LAP_BITS        = lcrb_pkg::DEF_LAP_BITS,
	parameter int BA_W            = 12,
	parameter int LA_W            = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          command,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [5:0]          cursor_slot,
	input  logic [31:0]         cursor_lap,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [6:0]          cfg_data,
	output logic                q_push,
	output lcrb_pkg::job_t      q_job,
	input  logic                q_full,
	input  logic                heavy_done,
	output lcrb_pkg::cfg_t      cfg_o,
	output logic                hold_o,
	output logic                bw_en,
	output logic [BA_W-1:0]     bw_addr,
	output logic [7:0]          bw_data,
	output logic                lw_en,
	output logic [LA_W-1:0]     lw_addr,
	output logic [6:0]          lw_data
);

	localparam int CMP_W = (LAP_BITS > 32) ? LAP_BITS : 32;
	localparam logic [CMP_W-1:0] LAP_MASK = {CMP_W{1'b1}} >> (CMP_W - LAP_BITS);

	logic [6:0]          chunk_q, nodes_q, fill_q;
	logic [6:0]          wslot_q, woff_q;
	logic [LAP_BITS-1:0] wlap_q;
	logic [15:0]         offered_q;
	logic                hold_q;

	logic                accept, push_c, heavy_c;
	lcrb_pkg::job_t      job_c;
	logic [6:0]          cs7, ns7, wslot_inc, woff_n;
	logic                cs_ok, same_lap, prev_lap, rd_wrap, ws_wrap, fits;
	logic [CMP_W-1:0]    cl_w, wl_w, lap_inc;
	logic [5:0]          res_ns;
	logic [31:0]         res_nl;
	logic [15:0]         offered_n;

	assign cfg_ready = 1'b1;
	assign in_stall  = hold_q || q_full;
	assign accept    = in_valid && !in_stall;
	assign hold_o    = hold_q;
	assign cfg_o     = '{chunk_size: chunk_q, nodes: nodes_q, fill: fill_q};

	assign cs7      = {1'b0, cursor_slot};
	assign cs_ok    = cs7 < nodes_q;
	assign cl_w     = CMP_W'(cursor_lap);
	assign wl_w     = CMP_W'(wlap_q);
	assign same_lap = cl_w == wl_w;
	// previous lap exists only once the writer has wrapped at least once
	assign prev_lap = (wlap_q != '0) && (cl_w == CMP_W'(wlap_q - 1'b1));

	assign ns7     = cs7 + 7'd1;
	assign rd_wrap = ns7 >= nodes_q;
	assign lap_inc = (cl_w + 1'b1) & LAP_MASK;
	assign res_ns  = rd_wrap ? 6'd0 : ns7[5:0];
	assign res_nl  = rd_wrap ? lap_inc[31:0] : cursor_lap;

	assign fits      = woff_q < chunk_q;
	assign woff_n    = fits ? woff_q + 7'd1 : woff_q;
	assign offered_n = (offered_q == 16'hFFFF) ? offered_q : offered_q + 16'd1;
	assign wslot_inc = wslot_q + 7'd1;
	assign ws_wrap   = wslot_inc >= nodes_q;

	always_comb begin
		job_c = '{kind: lcrb_pkg::JOB_EMIT, status: lcrb_pkg::ST_OK, amount: 16'd0,
			res_slot: cursor_slot, res_lap: cursor_lap, cs: cursor_slot, wslot: wslot_q};
		push_c  = 1'b1;
		heavy_c = 1'b0;
		unique case (command)
			lcrb_pkg::CMD_WRITE: begin
				push_c       = last_byte;
				job_c.amount = offered_n;
			end
			lcrb_pkg::CMD_READ: begin
				if (cs_ok && same_lap && cs7 == wslot_q) begin
					job_c.status = lcrb_pkg::ST_EMPTY;
				end else if (cs_ok && ((same_lap && cs7 < wslot_q) ||
						(prev_lap && cs7 > wslot_q))) begin
					heavy_c        = 1'b1;
					job_c.kind     = lcrb_pkg::JOB_READ;
					job_c.res_slot = res_ns;
					job_c.res_lap  = res_nl;
				end else begin
					job_c.status = lcrb_pkg::ST_BAD;
				end
			end
			lcrb_pkg::CMD_AVAIL: begin
				if (!cs_ok) begin
					job_c.status = lcrb_pkg::ST_BAD;
				end else if ((same_lap && cs7 < wslot_q) ||
						(prev_lap && cs7 > wslot_q)) begin
					heavy_c    = 1'b1;
					job_c.kind = lcrb_pkg::JOB_AVAIL;
				end
			end
			lcrb_pkg::CMD_POS: begin
				job_c.res_slot = wslot_q[5:0];
				job_c.res_lap  = wl_w[31:0];
			end
			lcrb_pkg::CMD_CLEAR: begin
				job_c.status = lcrb_pkg::ST_OK;
			end
			default: begin
				job_c.status = lcrb_pkg::ST_BAD;
			end
		endcase
	end

	assign q_push = accept && push_c;
	assign q_job  = job_c;

	assign bw_en   = accept && command == lcrb_pkg::CMD_WRITE && fits;
	assign bw_addr = BA_W'(wslot_q) * BA_W'(MAX_CHUNK_BYTES) + BA_W'(woff_q);
	assign bw_data = data_byte;
	assign lw_en   = accept && command == lcrb_pkg::CMD_WRITE && last_byte;
	assign lw_addr = LA_W'(wslot_q);
	assign lw_data = woff_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q   <= lcrb_pkg::clamp_reg(lcrb_pkg::REG_RESET_VALUE, MAX_CHUNK_BYTES);
			nodes_q   <= lcrb_pkg::clamp_reg(lcrb_pkg::REG_RESET_VALUE, MAX_SLOTS);
			fill_q    <= '0;
			wslot_q   <= '0;
			wlap_q    <= '0;
			woff_q    <= '0;
			offered_q <= '0;
			hold_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == lcrb_pkg::REG_CHUNK_SIZE)
					chunk_q <= lcrb_pkg::clamp_reg(cfg_data, MAX_CHUNK_BYTES);
				else
					nodes_q <= lcrb_pkg::clamp_reg(cfg_data, MAX_SLOTS);
				// every length falls back to chunk_size: forget written slots
				fill_q    <= '0;
				wslot_q   <= '0;
				wlap_q    <= '0;
				woff_q    <= '0;
				offered_q <= '0;
			end else if (accept) begin
				if (command == lcrb_pkg::CMD_WRITE) begin
					if (last_byte) begin
						woff_q    <= '0;
						offered_q <= '0;
						wslot_q   <= ws_wrap ? 7'd0 : wslot_inc;
						if (ws_wrap)
							wlap_q <= wlap_q + 1'b1;
						if (wslot_inc > fill_q)
							fill_q <= wslot_inc;
					end else begin
						woff_q    <= woff_n;
						offered_q <= offered_n;
					end
				end else if (command == lcrb_pkg::CMD_CLEAR) begin
					wslot_q   <= '0;
					wlap_q    <= '0;
					woff_q    <= '0;
					offered_q <= '0;
				end
				if (heavy_c)
					hold_q <= 1'b1;
			end
			if (heavy_done)
				hold_q <= 1'b0;
		end
	end

endmodule

### rtl/lcrb_back.sv
// Lapped chunk ring buffer: back end. Pops jobs, streams chunk bytes,
// walks slot lengths for available, and owns the output register.
// Depends on lcrb_pkg.
module lcrb_back #(
	parameter int MAX_CHUNK_BYTES = lcrb_pkg::DEF_MAX_CHUNK_BYTES,
	parameter int BA_W            = 12,
	parameter int LA_W            = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  lcrb_pkg::job_t  q_head,
	output logic            q_pop,
	input  lcrb_pkg::cfg_t  cfg_i,
	output logic            heavy_done,
	output logic            br_en,
	output logic [BA_W-1:0] br_addr,
	input  logic [7:0]      br_data,
	output logic            lr_en,
	output logic [LA_W-1:0] lr_addr,
	input  logic [6:0]      lr_data,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      status,
	output logic [7:0]      out_byte,
	output logic            last_out,
	output logic [15:0]     amount,
	output logic [5:0]      next_slot,
	output logic [31:0]     next_lap
);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_EMIT  = 3'd1;
	localparam logic [2:0] B_RLEN  = 3'd2;
	localparam logic [2:0] B_RBYTE = 3'd3;
	localparam logic [2:0] B_AVAIL = 3'd4;
	localparam logic [2:0] B_AVOUT = 3'd5;

	logic [2:0]     st_q, st_n;
	lcrb_pkg::job_t job_q;
	logic [6:0]     len_q, k_q, idx_q, idx_s1;
	logic           pend_q, iss_all_q, pend_s1;
	logic [15:0]    acc_q;

	logic           out_valid_q, out_free, load_c;
	logic [1:0]     ld_status;
	logic [7:0]     ld_byte;
	logic           ld_last;
	logic [15:0]    ld_amount;
	logic [5:0]     ld_slot;
	logic [31:0]    ld_lap;

	logic [6:0]     len_raw, len_c, idx_nx, av_len;
	logic           take, issue, av_issue;
	logic [16:0]    sum17;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// a slot never written since the last register write reads as chunk_size
	assign len_raw = ({1'b0, job_q.cs} < cfg_i.fill) ? lr_data : cfg_i.chunk_size;
	always_comb begin
		len_c = len_raw;
		if (len_raw == 7'd0)
			len_c = 7'd1;
		else if (len_raw > 7'(MAX_CHUNK_BYTES))
			len_c = 7'(MAX_CHUNK_BYTES);
	end

	assign take  = (st_q == B_RBYTE) && pend_q && out_free;
	assign issue = (st_q == B_RBYTE) && (!pend_q || take) && !iss_all_q;

	assign idx_nx   = (idx_q + 7'd1 == cfg_i.nodes) ? 7'd0 : idx_q + 7'd1;
	assign av_issue = (st_q == B_AVAIL) && !iss_all_q;
	assign av_len   = (idx_s1 < cfg_i.fill) ? lr_data : cfg_i.chunk_size;
	assign sum17    = {1'b0, acc_q} + 17'(av_len);

	always_comb begin
		st_n       = st_q;
		q_pop      = 1'b0;
		heavy_done = 1'b0;
		lr_en      = 1'b0;
		lr_addr    = LA_W'(idx_q);
		load_c     = 1'b0;
		ld_status  = lcrb_pkg::ST_OK;
		ld_byte    = 8'd0;
		ld_last    = 1'b1;
		ld_amount  = 16'd0;
		ld_slot    = job_q.res_slot;
		ld_lap     = job_q.res_lap;
		unique case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (q_head.kind)
						lcrb_pkg::JOB_READ: begin
							lr_en   = 1'b1;
							lr_addr = LA_W'(q_head.cs);
							st_n    = B_RLEN;
						end
						lcrb_pkg::JOB_AVAIL: st_n = B_AVAIL;
						default:             st_n = B_EMIT;
					endcase
				end
			end
			B_EMIT: begin
				if (out_free) begin
					load_c    = 1'b1;
					ld_status = job_q.status;
					ld_amount = job_q.amount;
					st_n      = B_IDLE;
				end
			end
			B_RLEN: st_n = B_RBYTE;
			B_RBYTE: begin
				if (take) begin
					load_c    = 1'b1;
					ld_byte   = br_data;
					ld_last   = iss_all_q;
					ld_amount = 16'(len_q);
					if (iss_all_q) begin
						heavy_done = 1'b1;
						st_n       = B_IDLE;
					end
				end
			end
			B_AVAIL: begin
				lr_en = av_issue;
				if (iss_all_q && !pend_s1)
					st_n = B_AVOUT;
			end
			B_AVOUT: begin
				if (out_free) begin
					load_c     = 1'b1;
					ld_amount  = acc_q;
					heavy_done = 1'b1;
					st_n       = B_IDLE;
				end
			end
			default: st_n = B_IDLE;
		endcase
	end

	assign br_en   = issue;
	assign br_addr = BA_W'(job_q.cs) * BA_W'(MAX_CHUNK_BYTES) + BA_W'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			iss_all_q   <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			st_q <= st_n;
			if (load_c)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (st_q == B_IDLE) begin
				iss_all_q <= 1'b0;
				pend_q    <= 1'b0;
				pend_s1   <= 1'b0;
			end else if (st_q == B_RBYTE) begin
				if (issue) begin
					pend_q    <= 1'b1;
					iss_all_q <= (k_q + 7'd1 == len_q);
				end else if (take) begin
					pend_q <= 1'b0;
				end
			end else if (st_q == B_AVAIL) begin
				pend_s1 <= av_issue;
				if (av_issue)
					iss_all_q <= (idx_nx == job_q.wslot);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
			idx_q <= {1'b0, q_head.cs};
			acc_q <= 16'd0;
		end
		if (st_q == B_RLEN) begin
			len_q <= len_c;
			k_q   <= 7'd0;
		end
		if (issue)
			k_q <= k_q + 7'd1;
		if (av_issue) begin
			idx_q  <= idx_nx;
			idx_s1 <= idx_q;
		end
		if (st_q == B_AVAIL && pend_s1)
			acc_q <= sum17[16] ? 16'hFFFF : sum17[15:0];
		if (load_c) begin
			status    <= ld_status;
			out_byte  <= ld_byte;
			last_out  <= ld_last;
			amount    <= ld_amount;
			next_slot <= ld_slot;
			next_lap  <= ld_lap;
		end
	end

endmodule

### rtl/lapped_chunk_ring_buffer_core.sv
// Lapped chunk ring buffer: top level. Front end, job queue, back end,
// byte and length RAMs. Depends on lcrb_pkg and all lcrb_* modules.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | in_valid / in_stall     | command data_byte last_byte cursor_slot cursor_lap
//  out     | out_valid / out_stall   | status out_byte last_out amount next_slot next_lap
//  cfg     | cfg_valid / cfg_ready   | cfg_index cfg_data
//
// Write bytes are taken one per cycle unless in_stall is high; a chunk's last byte
// queues one result. Read: a length RAM read, then one byte per cycle from the byte
// RAM unless the output is stalled. Available: one length RAM read a cycle per slot walked.
// After a read or available word that walks the RAMs, the front stalls until its
// last result reaches the output register.
// Reset clears all positions; lengths of unwritten slots read as chunk_size.
// out_stall holds the output register; the queue lets the front keep taking writes.
module lapped_chunk_ring_buffer_core #(
	parameter int MAX_SLOTS       = lcrb_pkg::DEF_MAX_SLOTS,
	parameter int MAX_CHUNK_BYTES = lcrb_pkg::DEF_MAX_CHUNK_BYTES,
	parameter int LAP_BITS        = lcrb_pkg::DEF_LAP_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [5:0]  cursor_slot,
	input  logic [31:0] cursor_lap,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  out_byte,
	output logic        last_out,
	output logic [15:0] amount,
	output logic [5:0]  next_slot,
	output logic [31:0] next_lap,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int BYTE_DEPTH = MAX_SLOTS * MAX_CHUNK_BYTES;
	localparam int BA_W = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;
	localparam int LA_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	logic           q_push, q_pop, q_empty, q_full, heavy_done, hold;
	lcrb_pkg::job_t q_job, q_head;
	lcrb_pkg::cfg_t cfg;
	logic           bw_en, br_en, lw_en, lr_en;
	logic [BA_W-1:0] bw_addr, br_addr;
	logic [LA_W-1:0] lw_addr, lr_addr;
	logic [7:0]     bw_data, br_data;
	logic [6:0]     lw_data, lr_data;

	lcrb_front #(
		.MAX_SLOTS(MAX_SLOTS), .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES),
		.LAP_BITS(LAP_BITS), .BA_W(BA_W), .LA_W(LA_W)
	) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .data_byte, .last_byte,
		.cursor_slot, .cursor_lap, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.q_push, .q_job, .q_full, .heavy_done, .cfg_o(cfg), .hold_o(hold),
		.bw_en, .bw_addr, .bw_data, .lw_en, .lw_addr, .lw_data
	);

	lcrb_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_job(q_job), .pop(q_pop),
		.head(q_head), .empty(q_empty), .full(q_full)
	);

	lcrb_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH), .ADDR_W(BA_W)) u_byte_ram (
		.clk, .wr_en(bw_en), .wr_addr(bw_addr), .wr_data(bw_data),
		.rd_en(br_en), .rd_addr(br_addr), .rd_data(br_data)
	);

	lcrb_ram #(.WIDTH(7), .DEPTH(MAX_SLOTS), .ADDR_W(LA_W)) u_len_ram (
		.clk, .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(lw_data),
		.rd_en(lr_en), .rd_addr(lr_addr), .rd_data(lr_data)
	);

	lcrb_back #(
		.MAX_CHUNK_BYTES(MAX_CHUNK_BYTES), .BA_W(BA_W), .LA_W(LA_W)
	) u_back (
		.clk, .arst_n, .q_empty, .q_head, .q_pop, .cfg_i(cfg), .heavy_done,
		.br_en, .br_addr, .br_data, .lr_en, .lr_addr, .lr_data,
		.out_valid, .out_stall, .status, .out_byte, .last_out, .amount,
		.next_slot, .next_lap
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("job pushed into a full queue");

	a_done_only_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		heavy_done |-> hold) else $error("read/available finished with front not held");

	a_hold_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> in_stall) else $error("input taken while a read/available is running");

	a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("pop from an empty queue");

endmodule

### tb/lapped_chunk_ring_buffer_checker.sv
`timescale 1ns / 100ps
// Checker for the lapped chunk ring buffer: watches the input, output and
// register channels, predicts every result and compares. Uses lcrb_pkg.
module lapped_chunk_ring_buffer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [5:0]  cursor_slot,
	input  logic [31:0] cursor_lap,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [7:0]  out_byte,
	input  logic        last_out,
	input  logic [15:0] amount,
	input  logic [5:0]  next_slot,
	input  logic [31:0] next_lap,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output int          errors,
	output int          pending
);
	import lcrb_pkg::*;

	localparam int SLOTS = 64;
	localparam int CHUNK = 64;

	typedef struct {
		logic [1:0]  st;
		logic [7:0]  data;
		logic        last;
		logic [15:0] amt;
		logic [5:0]  slot;
		logic [31:0] lap;
	} result_t;

	result_t     expected_results[$];
	logic [7:0]  ring_bytes[SLOTS][CHUNK];
	int          ring_len[SLOTS];
	int          wr_slot, wr_offset, offered, chunk_bytes, ring_nodes;
	logic [31:0] wr_lap;

	assign pending = expected_results.size();

	function automatic int clamp_value(logic [6:0] v, int hi);
		if (v == 0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic void restart_ring();
		for (int s = 0; s < SLOTS; s++) begin
			ring_len[s] = chunk_bytes;
			for (int b = 0; b < CHUNK; b++)
				ring_bytes[s][b] = 8'd0;
		end
		wr_slot = 0;
		wr_lap = 0;
		wr_offset = 0;
		offered = 0;
	endfunction

	function automatic void push_result(logic [1:0] st, logic [7:0] d, logic l, int amt,
			logic [5:0] sl, logic [31:0] lp);
		result_t r;
		r.st = st;
		r.data = d;
		r.last = l;
		r.amt = 16'(amt);
		r.slot = sl;
		r.lap = lp;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_word(logic [2:0] cmd, logic [7:0] d, logic l,
			logic [5:0] cs, logic [31:0] cl);
		logic        prev_lap, same_lap;
		logic [1:0]  st;
		logic [5:0]  ns;
		logic [31:0] nl;
		int          n, total;
		prev_lap = (wr_lap >= 1) && (cl == wr_lap - 32'd1);
		same_lap = (cl == wr_lap);
		case (cmd)
			CMD_WRITE: begin
				if (wr_offset < chunk_bytes) begin
					ring_bytes[wr_slot][wr_offset] = d;
					wr_offset++;
				end
				if (offered < 65535)
					offered++;
				if (l) begin
					ring_len[wr_slot] = wr_offset;
					push_result(ST_OK, 8'd0, 1'b1, offered, cs, cl);
					wr_slot++;
					if (wr_slot >= ring_nodes) begin
						wr_slot = 0;
						wr_lap = wr_lap + 32'd1;
					end
					wr_offset = 0;
					offered = 0;
				end
			end
			CMD_READ: begin
				st = ST_BAD;
				if (cs < ring_nodes) begin
					if (same_lap)
						st = cs < wr_slot ? ST_OK : (cs == wr_slot ? ST_EMPTY : ST_BAD);
					else if (prev_lap)
						st = cs > wr_slot ? ST_OK : ST_BAD;
				end
				if (st != ST_OK) begin
					push_result(st, 8'd0, 1'b1, 0, cs, cl);
				end else begin
					n = ring_len[cs];
					ns = cs + 6'd1;
					nl = cl;
					if (int'(cs) + 1 >= ring_nodes) begin
						ns = 6'd0;
						nl = cl + 32'd1;
					end
					for (int k = 0; k < n; k++)
						push_result(ST_OK, ring_bytes[cs][k], k + 1 == n, n, ns, nl);
				end
			end
			CMD_AVAIL: begin
				total = 0;
				if (cs >= ring_nodes) begin
					push_result(ST_BAD, 8'd0, 1'b1, 0, cs, cl);
				end else begin
					if (same_lap) begin
						for (int i = cs; i < wr_slot; i++)
							total += ring_len[i];
					end else if (prev_lap && cs > wr_slot) begin
						for (int i = cs; i < ring_nodes; i++)
							total += ring_len[i];
						for (int i = 0; i < wr_slot; i++)
							total += ring_len[i];
					end
					if (total > 65535)
						total = 65535;
					push_result(ST_OK, 8'd0, 1'b1, total, cs, cl);
				end
			end
			CMD_POS:
				push_result(ST_OK, 8'd0, 1'b1, 0, 6'(wr_slot), wr_lap);
			CMD_CLEAR: begin
				wr_slot = 0;
				wr_lap = 0;
				wr_offset = 0;
				offered = 0;
				push_result(ST_OK, 8'd0, 1'b1, 0, cs, cl);
			end
			default:
				push_result(ST_BAD, 8'd0, 1'b1, 0, cs, cl);
		endcase
	endfunction

	task automatic report(string field, longint exp_v, longint got_v);
		$display("%0t mismatch %s: expected %0h got %0h", $realtime, field, exp_v, got_v);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		if (!arst_n) begin
			chunk_bytes = clamp_value(REG_RESET_VALUE, CHUNK);
			ring_nodes = clamp_value(REG_RESET_VALUE, SLOTS);
			restart_ring();
			expected_results.delete();
		end else begin
			// pop before push: a word taken this edge cannot have a result out yet
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report("unexpected word", 0, {status, out_byte, amount});
				end else begin
					r = expected_results.pop_front();
					if (status !== r.st) report("status", r.st, status);
					if (out_byte !== r.data) report("out_byte", r.data, out_byte);
					if (last_out !== r.last) report("last_out", r.last, last_out);
					if (amount !== r.amt) report("amount", r.amt, amount);
					if (next_slot !== r.slot) report("next_slot", r.slot, next_slot);
					if (next_lap !== r.lap) report("next_lap", r.lap, next_lap);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CHUNK_SIZE)
					chunk_bytes = clamp_value(cfg_data, CHUNK);
				else
					ring_nodes = clamp_value(cfg_data, SLOTS);
				restart_ring();
			end
			if (in_valid && !in_stall)
				predict_word(command, data_byte, last_byte, cursor_slot, cursor_lap);
		end
	end
endmodule

### tb/lapped_chunk_ring_buffer_core_tb.sv
`timescale 1ns / 100ps
// Top of the ring buffer testbench: clock, reset, stimulus, output stall
// and verdict. Uses lcrb_pkg, the core and lapped_chunk_ring_buffer_checker.
module lapped_chunk_ring_buffer_core_tb;
	import lcrb_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE = 30;

	logic        clk, arst_n;
	logic        in_valid, in_stall, last_byte, out_valid, out_stall, last_out;
	logic [2:0]  command;
	logic [7:0]  data_byte, out_byte;
	logic [5:0]  cursor_slot, next_slot;
	logic [31:0] cursor_lap, next_lap;
	logic [1:0]  status;
	logic [15:0] amount;
	logic        cfg_valid, cfg_ready, cfg_index;
	logic [6:0]  cfg_data;
	int          errors, pending;

	// writer position as the stimulus sees it, for aiming cursors
	int          w_slot, nodes;
	logic [31:0] w_lap;
	bit          tx_quiet;
	int          idle_cycles;

	lapped_chunk_ring_buffer_core dut (.*);

	lapped_chunk_ring_buffer_checker chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("lapped_chunk_ring_buffer_core test failed");
			$finish;
		end
	end

	// receiver: random stall per word, quiet stretches, one long hold-off
	initial begin
		int hold, taken;
		bit rx_quiet;
		hold = 0;
		taken = 0;
		rx_quiet = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				taken++;
				if (taken % 50 == 0)
					rx_quiet = !rx_quiet;
				if (taken == 60)
					hold = 400;
				else
					hold = rx_quiet ? 0 : $urandom_range(0, 17);
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(logic [2:0] cmd, logic [7:0] d, logic l, logic [5:0] cs,
			logic [31:0] cl, bit no_gap = 0);
		int gap;
		gap = (tx_quiet || no_gap) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= d;
		last_byte <= l;
		cursor_slot <= cs;
		cursor_lap <= cl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (cmd == CMD_WRITE && l) begin
			w_slot++;
			if (w_slot >= nodes) begin
				w_slot = 0;
				w_lap++;
			end
		end else if (cmd == CMD_CLEAR) begin
			w_slot = 0;
			w_lap = 0;
		end
	endtask

	task automatic write_reg(logic idx, logic [6:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// a partial chunk gives no result, so let the core settle
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_NODES)
			nodes = value == 0 ? 1 : (value > 64 ? 64 : int'(value));
		w_slot = 0;
		w_lap = 0;
	endtask

	task automatic write_chunk(int n, logic [5:0] cs, logic [31:0] cl);
		for (int i = 0; i < n; i++)
			send_word(CMD_WRITE, 8'($urandom), i == n - 1, cs, cl);
	endtask

	task automatic random_word();
		int pick;
		logic [5:0] cs;
		logic [31:0] cl;
		pick = $urandom_range(0, 99);
		cs = 6'($urandom_range(0, nodes - 1));
		cl = (w_lap >= 1 && $urandom_range(0, 1)) ? w_lap - 1 : w_lap;
		if ($urandom_range(0, 9) == 0)
			cl = w_lap + 1;
		if (pick < 55)
			send_word(CMD_WRITE, 8'($urandom), $urandom_range(0, 2) == 0,
				6'($urandom), $urandom);
		else if (pick < 75)
			send_word(CMD_READ, 8'($urandom), 1'($urandom), cs, cl);
		else if (pick < 85)
			send_word(CMD_AVAIL, 8'($urandom), 1'($urandom), cs, cl);
		else if (pick < 90)
			send_word(CMD_POS, 8'($urandom), 1'($urandom), cs, cl);
		else if (pick < 93)
			send_word(CMD_CLEAR, 8'($urandom), 1'($urandom), cs, cl);
		else
			send_word(3'($urandom), 8'($urandom), 1'($urandom), 6'($urandom), $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_WRITE;
		data_byte = 8'd0;
		last_byte = 1'b0;
		cursor_slot = 6'd0;
		cursor_lap = 32'd0;
		cfg_valid = 1'b0;
		cfg_index = REG_CHUNK_SIZE;
		cfg_data = 7'd0;
		w_slot = 0;
		w_lap = 0;
		nodes = 64;
		tx_quiet = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: empty ring, bad cursors, spare codes
		send_word(CMD_POS, 8'd0, 1'b0, 6'd0, 32'd0);
		send_word(CMD_AVAIL, 8'd0, 1'b0, 6'd0, 32'd0);
		send_word(CMD_READ, 8'd0, 1'b0, 6'd0, 32'd0);
		send_word(CMD_READ, 8'd0, 1'b0, 6'd5, 32'd0);
		send_word(CMD_WRITE, 8'h00, 1'b0, 6'd63, 32'hFFFF_FFFF);
		send_word(CMD_WRITE, 8'hFF, 1'b1, 6'd63, 32'hFFFF_FFFF);
		send_word(CMD_READ, 8'd0, 1'b0, 6'd0, 32'd0);
		send_word(CMD_AVAIL, 8'd0, 1'b0, 6'd0, 32'd0);
		send_word(CMD_READ, 8'd0, 1'b0, 6'd0, 32'hFFFF_FFFF);
		send_word(CMD_SPARE_LO, 8'd0, 1'b0, 6'd1, 32'd1);
		send_word(CMD_SPARE_HI, 8'd0, 1'b0, 6'd2, 32'd2);
		send_word(CMD_CLEAR, 8'd0, 1'b0, 6'd3, 32'd3);

		// out-of-range register values clamp
		write_reg(REG_CHUNK_SIZE, 7'd0);
		write_reg(REG_NODES, 7'd127);
		write_chunk(3, 6'd0, 32'd0);
		send_word(CMD_READ, 8'd0, 1'b0, 6'd0, 32'd0);

		// two slots: previous lap read and overrun
		write_reg(REG_CHUNK_SIZE, 7'd3);
		write_reg(REG_NODES, 7'd2);
		write_chunk(2, 6'd0, 32'd0);
		write_chunk(4, 6'd0, 32'd0);
		send_word(CMD_AVAIL, 8'd0, 1'b0, 6'd1, 32'd0);
		send_word(CMD_READ, 8'd0, 1'b0, 6'd1, 32'd0);
		send_word(CMD_READ, 8'd0, 1'b0, 6'd0, 32'd0);
		send_word(CMD_READ, 8'd0, 1'b0, 6'd2, 32'd1);

		// random phases over several sizes, extremes included
		for (int ph = 0; ph < 7; ph++) begin
			tx_quiet = (ph % 3 == 2);
			if (ph == 0) begin
				write_reg(REG_CHUNK_SIZE, 7'd64);
				write_reg(REG_NODES, 7'd64);
			end else if (ph == 1) begin
				write_reg(REG_CHUNK_SIZE, 7'd1);
				write_reg(REG_NODES, 7'd1);
			end else begin
				write_reg(REG_CHUNK_SIZE, 7'($urandom_range(1, 8)));
				write_reg(REG_NODES, 7'($urandom_range(1, 8)));
			end
			for (int n = 0; n < 14; n++)
				random_word();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("lapped_chunk_ring_buffer_core test passed");
		else
			$display("lapped_chunk_ring_buffer_core test failed");
		$finish;
	end
endmodule

### filelist.f
rtl/lcrb_pkg.sv
rtl/lcrb_ram.sv
rtl/lcrb_queue.sv
rtl/lcrb_front.sv
rtl/lcrb_back.sv
rtl/lapped_chunk_ring_buffer_core.sv
tb/lapped_chunk_ring_buffer_checker.sv
tb/lapped_chunk_ring_buffer_core_tb.sv
